// ----- src/button_click_classifier_defines.svh -----
// assertion macros used by the button click classifier rtl
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bcc_pkg.sv -----
// shared types and constants of the button click classifier
`default_nettype none

package bcc_pkg;

  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned STABLE_W   = 9;
  localparam int unsigned EDGE_W     = 4;
  localparam int unsigned GESTURE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 16'd500;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd50;

  localparam logic [STABLE_W-1:0] STABLE_MAX = 9'd511;
  localparam logic [EDGE_W-1:0]   EDGE_MAX   = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd1;

  localparam logic [GESTURE_W-1:0] G_NONE  = 3'd0;
  localparam logic [GESTURE_W-1:0] G_CLICK = 3'd1;
  localparam logic [GESTURE_W-1:0] G_TWICE = 3'd2;
  localparam logic [GESTURE_W-1:0] G_TRICE = 3'd3;
  localparam logic [GESTURE_W-1:0] G_HELD  = 3'd4;

  typedef struct packed {
    logic [WINDOW_W-1:0]   window_ticks;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
  } bcc_cfg_t;

endpackage

`default_nettype wire

// ----- src/bcc_if.sv -----
// valid/ready channel interfaces for samples and gestures
`default_nettype none

interface bcc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture;

  modport source (output valid, output gesture, input ready);
  modport sink (input valid, input gesture, output ready);
endinterface

`default_nettype wire

// ----- src/bcc_core.sv -----
// gesture state machine: debounce, edge counting, window and evaluation
`default_nettype none

`include "button_click_classifier_defines.svh"

module bcc_core import bcc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 level,
  input  wire bcc_cfg_t             cfg,
  output logic [GESTURE_W-1:0]      gesture_nxt
);

  typedef enum logic [1:0] {PH_IDLE, PH_LOG, PH_EVAL, PH_RESET} phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  last_level_r, last_level_nxt;
  logic [STABLE_W-1:0]   stable_r, stable_nxt;
  logic                  rise_armed_r, rise_armed_nxt;
  logic                  fall_armed_r, fall_armed_nxt;
  logic [EDGE_W-1:0]     rise_total_r, rise_total_nxt;
  logic [EDGE_W-1:0]     fall_total_r, fall_total_nxt;
  logic [WINDOW_W-1:0]   elapsed_r, elapsed_nxt;
  logic [GESTURE_W-1:0]  gesture_r;

  always_comb begin
    phase_nxt      = phase_r;
    last_level_nxt = last_level_r;
    rise_armed_nxt = rise_armed_r;
    fall_armed_nxt = fall_armed_r;
    rise_total_nxt = rise_total_r;
    fall_total_nxt = fall_total_r;
    elapsed_nxt    = elapsed_r;
    gesture_nxt    = gesture_r;
    stable_nxt     = (stable_r == STABLE_MAX) ? stable_r : stable_r + 1'b1;

    case (phase_r)
      PH_IDLE: begin
        if (level) begin
          elapsed_nxt = '0;
          phase_nxt   = PH_LOG;
        end
      end
      PH_LOG: begin
        if (level != last_level_r) begin
          stable_nxt     = '0;
          rise_armed_nxt = 1'b1;
          fall_armed_nxt = 1'b1;
        end
        if (stable_nxt > {1'b0, cfg.debounce_ticks}) begin
          if (level && rise_armed_nxt) begin
            rise_armed_nxt = 1'b0;
            if (rise_total_r != EDGE_MAX) rise_total_nxt = rise_total_r + 1'b1;
          end
          if (!level && fall_armed_nxt) begin
            fall_armed_nxt = 1'b0;
            if (fall_total_r != EDGE_MAX) fall_total_nxt = fall_total_r + 1'b1;
          end
        end
        last_level_nxt = level;
        if (elapsed_r >= cfg.window_ticks) begin
          phase_nxt = PH_EVAL;
        end else begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end
      PH_EVAL: begin
        if (rise_total_r > fall_total_r) begin
          gesture_nxt = G_HELD;
        end else if (rise_total_r == fall_total_r) begin
          case (rise_total_r)
            4'd1:    gesture_nxt = G_CLICK;
            4'd2:    gesture_nxt = G_TWICE;
            4'd3:    gesture_nxt = G_TRICE;
            default: gesture_nxt = gesture_r;
          endcase
        end
        phase_nxt = PH_RESET;
      end
      PH_RESET: begin
        gesture_nxt    = G_NONE;
        rise_total_nxt = '0;
        fall_total_nxt = '0;
        phase_nxt      = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      last_level_r <= 1'b0;
      stable_r     <= '0;
      rise_armed_r <= 1'b0;
      fall_armed_r <= 1'b0;
      rise_total_r <= '0;
      fall_total_r <= '0;
      elapsed_r    <= '0;
      gesture_r    <= G_NONE;
    end else if (step) begin
      phase_r      <= phase_nxt;
      last_level_r <= last_level_nxt;
      stable_r     <= stable_nxt;
      rise_armed_r <= rise_armed_nxt;
      fall_armed_r <= fall_armed_nxt;
      rise_total_r <= rise_total_nxt;
      fall_total_r <= fall_total_nxt;
      elapsed_r    <= elapsed_nxt;
      gesture_r    <= gesture_nxt;
    end
  end

  `BCC_ASSERT_NOW(a_gesture_only_in_reset, gesture_r != G_NONE, phase_r == PH_RESET, "gesture outside reset phase")
  `BCC_ASSERT_NOW(a_idle_counts_clear, phase_r == PH_IDLE, rise_total_r == '0 && fall_total_r == '0, "edge counts not clear in idle")
  `BCC_ASSERT_NOW(a_window_bound, phase_r == PH_LOG, elapsed_r <= cfg.window_ticks, "window counter past window length")
  `BCC_ASSERT_NEXT(a_eval_then_reset, step && phase_r == PH_EVAL, phase_r == PH_RESET, "evaluate not followed by reset")

endmodule

`default_nettype wire

// ----- src/button_click_classifier.sv -----
// out valid rises once the accepted sample moves from the input register into the result register; out stall holds it
// throughput: one sample transaction per clock cycle, sustained under no backpressure
// the input register and the result register form a two-stage valid/ready pipeline
// reset: synchronous on rst_n low; clears state, counters and both pipeline stages
// reset also loads window_ticks 500 and debounce_ticks 50
`default_nettype none

module button_click_classifier import bcc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bcc_in_if.sink                     in_ch,
  bcc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  bcc_cfg_t              cfg_r;
  logic                  in_valid_r;
  logic                  in_level_r;
  logic                  out_valid_r;
  logic [GESTURE_W-1:0]  out_gesture_r;
  logic [GESTURE_W-1:0]  gesture_nxt;
  logic                  advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = out_gesture_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks   <= WINDOW_RESET;
      cfg_r.debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW:   cfg_r.window_ticks   <= cfg_data[WINDOW_W-1:0];
        CFG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_level_r <= in_ch.pin_level;
    if (advance) out_gesture_r <= gesture_nxt;
  end

  bcc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .level       (in_level_r),
    .cfg         (cfg_r),
    .gesture_nxt (gesture_nxt)
  );

endmodule

`default_nettype wire
